/* rtl/core/bca_pkg.sv */
// ============================================================================
// Block covariance accumulator package
// Shared widths, register indexes and controller/datapath interface types.
// ============================================================================
package bca_pkg;

    localparam int CHANNELS       = 3;
    localparam int CH_W           = 8;
    localparam int PIX_W          = CHANNELS * CH_W;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 2;
    // window item count: product of two clamped register values
    localparam int TGT_W          = 2 * CFG_W;
    // signed channel difference and product of two differences
    localparam int DIFF_W         = CH_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;

    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_LANES      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET_SIZE = 5'd8;

    // controller -> datapath
    typedef struct packed {
        logic acc;        // add the beat to the sums, count it
        logic div_load;   // last beat of window: load divider, clear sums
        logic div_step;   // one quotient bit per lane
        logic out_load;   // move quotients to the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic close;      // the beat on the input completes the window
        logic div_last;   // divider is on its final step
        logic out_free;   // output register can take a result this cycle
    } sts_t;

endpackage

/* rtl/core/bca_ctrl.sv */
// ============================================================================
// Block covariance accumulator controller
// Sequences accumulation, the shared divide and the result hand-off.
// ============================================================================
module bca_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bca_pkg::sts_t sts,
    output bca_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        case (state_reg)
            ST_ACC:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (sts.close)
                    begin
                        cmd.div_load = 1'b1;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        cmd.acc = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // wait for the output register to drain
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_div_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_HOLD))
        else $error("divider finish did not move to result hold");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACC) |-> (!cmd.acc && !cmd.div_load))
        else $error("beat taken while divider busy");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACC) |-> in_stall)
        else $error("input open while divider busy");

endmodule

/* rtl/core/bca_dpath.sv */
// ============================================================================
// Block covariance accumulator datapath
// Window registers, per-lane product sums, bit-serial divider, output register.
// ============================================================================
module bca_dpath
#(
    parameter int MAX_WINDOW = bca_pkg::DEF_MAX_WINDOW,
    parameter int LANES      = bca_pkg::DEF_LANES
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_we,
    input  logic [bca_pkg::CFG_IDX_W-1:0]                  cfg_index,
    input  logic [bca_pkg::CFG_W-1:0]                      cfg_data,
    input  logic [bca_pkg::PIX_W-1:0]                      pixel_a,
    input  logic [bca_pkg::PIX_W-1:0]                      pixel_b,
    input  logic [bca_pkg::PIX_W-1:0]                      mean_a,
    input  logic [bca_pkg::PIX_W-1:0]                      mean_b,
    input  logic                                           out_stall,
    output logic                                           out_valid,
    output wire  [bca_pkg::CHANNELS-1:0][bca_pkg::CH_W-1:0] cov,
    input  bca_pkg::cmd_t                                  cmd,
    output bca_pkg::sts_t                                  sts
);

    localparam int SUM_W   = bca_pkg::PROD_W + $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int MAG_W   = SUM_W - 1;
    // a window shrunk mid-way can leave a quotient as wide as the sum magnitude
    localparam int Q_STEPS = MAG_W;
    localparam int STEP_W  = $clog2(Q_STEPS);
    localparam int DSH_W   = MAG_W + bca_pkg::TGT_W - 1;
    localparam int CW      = bca_pkg::CH_W;

    logic [bca_pkg::CFG_W-1:0]  width_reg;
    logic [bca_pkg::CFG_W-1:0]  height_reg;
    logic [bca_pkg::TGT_W-1:0]  target;
    logic [bca_pkg::TGT_W-1:0]  seen_reg;
    logic [bca_pkg::TGT_W-1:0]  seen_plus;
    logic [STEP_W-1:0]          step_reg;
    logic [DSH_W-1:0]           dsh_reg;
    logic                       out_valid_reg;

    function automatic logic [bca_pkg::CFG_W-1:0] eff_size(input logic [bca_pkg::CFG_W-1:0] v);
        logic [bca_pkg::CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = bca_pkg::CFG_W'(1);
        end
        else if (32'(v) > MAX_WINDOW)
        begin
            r = bca_pkg::CFG_W'(MAX_WINDOW);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bca_pkg::CFG_RESET_SIZE;
            height_reg <= bca_pkg::CFG_RESET_SIZE;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bca_pkg::CFG_WIDTH_IDX)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == bca_pkg::CFG_HEIGHT_IDX)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    assign target    = {{bca_pkg::CFG_W{1'b0}}, eff_size(width_reg)}
                     * {{bca_pkg::CFG_W{1'b0}}, eff_size(height_reg)};
    assign seen_plus = seen_reg + bca_pkg::TGT_W'(1);

    assign sts.close    = (seen_plus >= target);
    assign sts.div_last = (step_reg == STEP_W'(Q_STEPS - 1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.div_load)
            begin
                seen_reg <= '0;
                step_reg <= '0;
            end
            else
            begin
                if (cmd.acc)
                begin
                    seen_reg <= seen_plus;
                end
                if (cmd.div_step)
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    // shared divisor, starts at target aligned to the top quotient bit
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dsh_reg <= {{(DSH_W - bca_pkg::TGT_W){1'b0}}, target} << (Q_STEPS - 1);
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
        end
    end

    for (genvar k = 0; k < bca_pkg::CHANNELS; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_on
            logic signed [bca_pkg::DIFF_W-1:0] da;
            logic signed [bca_pkg::DIFF_W-1:0] db;
            logic signed [bca_pkg::PROD_W-1:0] prod;
            logic signed [SUM_W-1:0]           sum_reg;
            logic signed [SUM_W-1:0]           sum_next;
            logic signed [SUM_W-1:0]           sum_neg;
            logic [MAG_W-1:0]                  mag;
            logic [MAG_W-1:0]                  rem_reg;
            logic [CW-1:0]                     q_reg;
            logic                              neg_reg;
            logic                              ge;
            logic [CW-1:0]                     cov_reg;

            always_comb
            begin
                da       = $signed({1'b0, pixel_a[CW*k +: CW]})
                         - $signed({1'b0, mean_a[CW*k +: CW]});
                db       = $signed({1'b0, pixel_b[CW*k +: CW]})
                         - $signed({1'b0, mean_b[CW*k +: CW]});
                prod     = da * db;
                sum_next = sum_reg
                         + {{(SUM_W - bca_pkg::PROD_W){prod[bca_pkg::PROD_W-1]}}, prod};
                sum_neg  = -sum_next;
                mag      = sum_next[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_next[MAG_W-1:0];
                ge       = ({{(DSH_W - MAG_W){1'b0}}, rem_reg} >= dsh_reg);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sum_reg <= '0;
                end
                else if (cmd.div_load)
                begin
                    sum_reg <= '0;
                end
                else if (cmd.acc)
                begin
                    sum_reg <= sum_next;
                end
            end

            // restoring divide on the magnitude, keep the low quotient byte
            always_ff @(posedge clk)
            begin
                if (cmd.div_load)
                begin
                    rem_reg <= mag;
                    neg_reg <= sum_next[SUM_W-1];
                    q_reg   <= '0;
                end
                else if (cmd.div_step)
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dsh_reg[MAG_W-1:0];
                    end
                    q_reg <= {q_reg[CW-2:0], ge};
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.out_load)
                begin
                    cov_reg <= neg_reg ? (~q_reg + CW'(1)) : q_reg;
                end
            end

            assign cov[k] = cov_reg;
        end
        else
        begin : g_off
            assign cov[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> (seen_reg == '0 && step_reg == '0))
        else $error("window count not cleared at close");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(cov)))
        else $error("stalled result changed");

endmodule

/* rtl/core/block_covariance_accumulator_top.sv */
// ============================================================================
// Block covariance accumulator
// Local-window covariance of two 3-channel images, one result per window.
// ============================================================================
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | pixel_a, pixel_b, mean_a, mean_b (24 b)
//  out     | out_valid/out_stall| cov_ch0, cov_ch1, cov_ch2 (8 b each)
//  cfg     | cfg_we             | cfg_index (0 width, 1 height), cfg_data
//
//  One beat per cycle while a window fills: each lane does a 9x9 signed
//  multiply and adds into its sum in the same cycle.
//  The beat that completes the window starts the shared bit-serial divider:
//  one step per magnitude bit of the sum, 25 bits with the default 16x16
//  maximum window (one quotient bit per lane per cycle), then the quotients
//  are handed to the output register once it is free. in_stall is high from
//  the last beat of a window until that hand-off. A waiting result does
//  not block the next window from filling; only the hand-off of a second
//  window's quotients waits while the result is still stalled.
//  Reset clears sums, counts and handshake state; window sizes return to 8.
//
// ============================================================================
module block_covariance_accumulator_top
#(
    parameter int MAX_WINDOW = bca_pkg::DEF_MAX_WINDOW,
    parameter int LANES      = bca_pkg::DEF_LANES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [bca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bca_pkg::CFG_W-1:0]     cfg_data,
    // pixel pair channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bca_pkg::PIX_W-1:0]     pixel_a,
    input  logic [bca_pkg::PIX_W-1:0]     pixel_b,
    input  logic [bca_pkg::PIX_W-1:0]     mean_a,
    input  logic [bca_pkg::PIX_W-1:0]     mean_b,
    // covariance result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bca_pkg::CH_W-1:0]      cov_ch0,
    output logic [bca_pkg::CH_W-1:0]      cov_ch1,
    output logic [bca_pkg::CH_W-1:0]      cov_ch2
);

    bca_pkg::cmd_t cmd;
    bca_pkg::sts_t sts;
    wire [bca_pkg::CHANNELS-1:0][bca_pkg::CH_W-1:0] cov;

    // sequence: accumulate, divide, hold for the output register
    bca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // sums, window count, divider and result register
    bca_dpath
    #(
        .MAX_WINDOW (MAX_WINDOW),
        .LANES      (LANES)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_a   (pixel_a),
        .pixel_b   (pixel_b),
        .mean_a    (mean_a),
        .mean_b    (mean_b),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cov       (cov),
        .cmd       (cmd),
        .sts       (sts)
    );

    // unpack lanes onto the per-channel result ports
    assign cov_ch0 = cov[0];
    assign cov_ch1 = cov[1];
    assign cov_ch2 = cov[2];

endmodule
